@@ rtl/core/zba_pkg.sv @@
// ----------------------------------------------------------------------------
// zba_pkg: shared definitions for the zone bitmap allocator
// Sizes of the bitmap memory, result and command codes, configuration
// register indexes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package zba_pkg;

    // Bitmap geometry.
    localparam int unsigned BITS_PER_MAP_BLOCK = 8192;
    localparam int unsigned MAX_MAP_BLOCKS     = 8;
    localparam int unsigned WORD_BITS          = 64;
    localparam int unsigned BIT_SEL_W          = $clog2(WORD_BITS);
    localparam int unsigned WORDS_PER_BLOCK    = BITS_PER_MAP_BLOCK / WORD_BITS;
    localparam int unsigned TOTAL_BITS         = BITS_PER_MAP_BLOCK * MAX_MAP_BLOCKS;
    localparam int unsigned TOTAL_WORDS        = TOTAL_BITS / WORD_BITS;
    localparam int unsigned WORD_AW            = $clog2(TOTAL_WORDS);
    localparam int unsigned WCNT_W             = $clog2(TOTAL_WORDS + 1);
    localparam int unsigned BIT_AW             = WORD_AW + BIT_SEL_W;

    // Field widths.
    localparam int unsigned ZONE_W   = 17;
    localparam int unsigned FDZ_W    = 16;
    localparam int unsigned MBLK_W   = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 17;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_FIRST_DATA_ZONE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ZONE_COUNT      = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAP_BLOCKS      = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_CLEAR = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd_code;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FIND,
        S_ALLOC,
        S_FREE_CHK,
        S_REJECT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic    capture;
        logic    clr_wr;
        logic    scan_clr;
        logic    rd_scan;
        logic    rd_free;
        logic    find_bit;
        logic    wr_alloc;
        logic    wr_free;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_free;
        logic words_zero;
        logic in_range;
        logic word_free;
        logic scan_more;
        logic rd_pend;
        logic bit_set;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/zba_dpath.sv @@
// ----------------------------------------------------------------------------
// zba_dpath: bitmap memory, configuration and result registers
// Holds the used-zone bitmap, the scan and clear counters, the lowest-zero
// finder and the output register of the result channel.
// ----------------------------------------------------------------------------
module zba_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  zba_pkg::t_dp_cmd               i_cmd,
    output zba_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_we,
    input  logic [zba_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [zba_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic [zba_pkg::TDATA_W-1:0]    i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [zba_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic [zba_pkg::STATUS_W-1:0]   o_m_tuser
);
    import zba_pkg::*;

    // Returns the position of the lowest clear bit of a word.
    function automatic logic [BIT_SEL_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_SEL_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) pos = BIT_SEL_W'(i);
        end
        return pos;
    endfunction

    logic [WORD_BITS-1:0] r_bitmap [TOTAL_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_AW-1:0]   r_chk_addr;
    logic                 r_pend;
    logic [WORD_AW-1:0]   r_clr_cnt;
    logic [WCNT_W-1:0]    r_scan_cnt;
    logic [BIT_SEL_W-1:0] r_bit;

    logic [FDZ_W-1:0]     r_fdz;
    logic [ZONE_W-1:0]    r_zcnt;
    logic [MBLK_W-1:0]    r_mblk;

    t_cmd_code            r_req;
    logic [ZONE_W-1:0]    r_zone;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ZONE_W-1:0]    r_out_zone;

    logic [MBLK_W-1:0]    blocks;
    logic [WCNT_W-1:0]    words;
    logic [ZONE_W-1:0]    diff;
    logic [WORD_AW-1:0]   free_addr;
    logic [BIT_SEL_W-1:0] free_bit;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ZONE_W-1:0]    alloc_zone;

    // Search length in words, with the block count saturated.
    assign blocks = (r_mblk > MBLK_W'(MAX_MAP_BLOCKS)) ? MBLK_W'(MAX_MAP_BLOCKS) : r_mblk;
    assign words  = WCNT_W'(blocks) * WCNT_W'(WORDS_PER_BLOCK);

    assign diff      = r_zone - ZONE_W'(r_fdz);
    assign free_addr = diff[BIT_AW-1:BIT_SEL_W];
    assign free_bit  = diff[BIT_SEL_W-1:0];

    assign alloc_zone = ZONE_W'(FDZ_W'(r_fdz)) + ZONE_W'({r_chk_addr, r_bit});

    assign rd_en   = i_cmd.rd_scan | i_cmd.rd_free;
    assign rd_addr = i_cmd.rd_free ? free_addr : r_scan_cnt[WORD_AW-1:0];

    always_comb begin
        wr_en   = i_cmd.clr_wr | i_cmd.wr_alloc | i_cmd.wr_free;
        wr_addr = r_chk_addr;
        wr_data = r_rdata | (WORD_BITS'(1) << r_bit);
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_cnt;
            wr_data = '0;
        end else if (i_cmd.wr_free) begin
            wr_addr = free_addr;
            wr_data = r_rdata & ~(WORD_BITS'(1) << free_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_bitmap[wr_addr] <= wr_data;
        if (rd_en) begin
            r_rdata    <= r_bitmap[rd_addr];
            r_chk_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= t_cmd_code'(i_s_tuser);
            r_zone <= i_s_tdata[ZONE_W-1:0];
        end
        if (i_cmd.find_bit) r_bit <= first_zero(r_rdata);
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_zone   <= i_cmd.wr_alloc ? alloc_zone : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_clr_cnt   <= '0;
            r_scan_cnt  <= '0;
            r_fdz       <= '0;
            r_zcnt      <= '0;
            r_mblk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_scan;
            if (i_cmd.clr_wr) r_clr_cnt <= r_clr_cnt + WORD_AW'(1);
            if (i_cmd.scan_clr) begin
                r_scan_cnt <= '0;
            end else if (i_cmd.rd_scan) begin
                r_scan_cnt <= r_scan_cnt + WCNT_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FIRST_DATA_ZONE: r_fdz  <= i_cfg_data[FDZ_W-1:0];
                    CFG_ZONE_COUNT:      r_zcnt <= i_cfg_data[ZONE_W-1:0];
                    CFG_MAP_BLOCKS:      r_mblk <= i_cfg_data[MBLK_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_free    = (r_req == CMD_FREE);
    assign o_stat.words_zero = (words == '0);
    assign o_stat.in_range   = (r_zone >= ZONE_W'(r_fdz)) && (r_zone < r_zcnt)
                               && ({1'b0, diff} < (ZONE_W + 1)'(TOTAL_BITS));
    assign o_stat.word_free  = r_pend && (r_rdata != '1);
    assign o_stat.scan_more  = (r_scan_cnt < words);
    assign o_stat.rd_pend    = r_pend;
    assign o_stat.bit_set    = r_rdata[free_bit];
    assign o_stat.clr_last   = (r_clr_cnt == WORD_AW'(TOTAL_WORDS - 1));
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_W - ZONE_W){1'b0}}, r_out_zone};
    assign o_m_tuser  = r_out_status;

    // A result is never loaded over one that the sink has not taken.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending transfer");

    // The clearing pass owns the memory; no read runs beside it.
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !rd_en)
        else $error("memory read during clearing pass");

    // An allocation only sets a bit in a word that still had a clear bit.
    a_alloc_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_alloc |-> (r_rdata != '1) && !r_rdata[r_bit])
        else $error("allocation into a full word");

endmodule

@@ rtl/core/zba_ctrl.sv @@
// ----------------------------------------------------------------------------
// zba_ctrl: request sequencer of the zone bitmap allocator
// Runs the clearing pass after reset, then takes one request at a time and
// steps the datapath through the scan, the bit update and the result.
// ----------------------------------------------------------------------------
module zba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  zba_pkg::t_dp_stat  i_stat,
    output zba_pkg::t_dp_cmd   o_cmd
);
    import zba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.in_range) begin
                        o_cmd.rd_free = 1'b1;
                        n_state       = S_FREE_CHK;
                    end else begin
                        n_state = S_REJECT;
                    end
                end else if (i_stat.words_zero) begin
                    n_state = S_REJECT;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.word_free) begin
                    n_state = S_FIND;
                end else if (i_stat.scan_more) begin
                    o_cmd.rd_scan = 1'b1;
                end else if (!i_stat.rd_pend) begin
                    n_state = S_REJECT;
                end
            end
            S_FIND: begin
                o_cmd.find_bit = 1'b1;
                n_state        = S_ALLOC;
            end
            S_ALLOC: begin
                if (i_stat.out_free) begin
                    o_cmd.wr_alloc   = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_FREE_CHK: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.wr_free    = i_stat.bit_set;
                    o_cmd.res_status = i_stat.bit_set ? ST_OK : ST_CLEAR;
                    n_state          = S_IDLE;
                end
            end
            S_REJECT: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = i_stat.is_free ? ST_RANGE : ST_FULL;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Reset always starts the clearing pass.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("reset did not start the clearing pass");

    // Every result ends its request.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (r_state == S_IDLE))
        else $error("result did not return to idle");

    // A scan read never goes beyond the configured map blocks.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_scan |-> i_stat.scan_more)
        else $error("scan read past the map blocks");

endmodule

@@ rtl/core/zone_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// zone_bitmap_allocator: used-zone bitmap with allocate and free requests
// Top level joining the request sequencer and the bitmap datapath.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024 x 64-bit bitmap memory and accepts
// no request during that time; configuration writes are taken at any time,
// as the configuration channel is always ready. Requests are handled one at
// a time. A free is captured in the idle state, the decode state checks the
// range and issues the memory read, and the free check state sees the
// registered read data and, once the result register is free, writes back
// the cleared bit if it was set and loads the result. A free that is out of
// range, or an allocation with no map blocks, goes from the decode state to
// the reject state instead. An allocation scans the bitmap one 64-bit word
// per cycle through the single memory read port, from word 0 up to map_blocks
// (saturated at 8) times 128 words, and stops at the first word with a clear
// bit; it reads up to 1024 words when the map is full. The result register
// decouples the two sides: a finished result may wait for the sink while the
// next request is accepted, and a request stalls only at its own result when
// the previous one has still not been taken.
// ----------------------------------------------------------------------------
module zone_bitmap_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [zba_pkg::TDATA_W-1:0]    i_s_tdata,   // [16:0] zone, [23:17] zero
    input  logic                           i_s_tuser,   // [0] cmd
    // Result channel.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [zba_pkg::TDATA_W-1:0]    o_m_tdata,   // [16:0] zone_out, [23:17] zero
    output logic [zba_pkg::STATUS_W-1:0]   o_m_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [zba_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [zba_pkg::CFG_DW-1:0]     i_cfg_data
);
    import zba_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_we;

    // Registers are plain flops with no side effects, so every write transfer
    // is taken at once. Index 3 and above are ignored.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // The sequencer raises ready only in its idle state, so a request
    // transfer always finds the datapath free to capture it.
    zba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // The datapath owns the bitmap, the configuration registers and the
    // result register that drives the master side.
    zba_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ verif/zone_bitmap_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_bitmap_allocator_tb: self-checking testbench for the zone bitmap allocator
// Drives allocate and free requests over the request stream and programs the
// three configuration registers between phases. A bit-level copy of the
// used-zone bitmap predicts every result, which is then compared field by field.
// ----------------------------------------------------------------------------
module zone_bitmap_allocator_tb;
    import zba_pkg::*;

    // Index 3 of the configuration channel holds no register; writes to it
    // must leave the block unchanged.
    localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

    localparam int unsigned ZONE_MAX        = (1 << ZONE_W) - 1;
    localparam int unsigned FDZ_MAX         = (1 << FDZ_W) - 1;
    localparam int unsigned RESET_CYCLES    = 9;
    // A full-map scan and the clearing pass after reset both end well within
    // this limit, so a quiet stretch that reaches it means a hang.
    localparam int unsigned WATCHDOG_LIMIT  = 20000;
    localparam int unsigned TAIL_CYCLES     = 1100;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 90;

    typedef struct packed {
        t_status           status;
        logic [ZONE_W-1:0] zone;
    } t_result;

    // DUT ports. Every input holds a known value from time zero.
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [TDATA_W-1:0]  i_s_tdata   = '0;   // [16:0] zone, [23:17] zero
    logic                i_s_tuser   = 1'b0; // [0] cmd
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [TDATA_W-1:0]  o_m_tdata;          // [16:0] zone_out, [23:17] zero
    logic [STATUS_W-1:0] o_m_tuser;          // [1:0] status
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_AW-1:0]   i_cfg_addr  = '0;
    logic [CFG_DW-1:0]   i_cfg_data  = '0;

    // Shadow copy of the block's state and registers.
    logic [WORD_BITS-1:0] used_map [TOTAL_WORDS];
    logic [FDZ_W-1:0]     model_fdz        = '0;
    logic [ZONE_W-1:0]    model_zone_count = '0;
    logic [MBLK_W-1:0]    model_map_blocks = '0;

    // Results still owed by the block, oldest first, and the bit indexes that
    // were handed out by allocations so that frees can target them.
    t_result     pending_results [$];
    int unsigned held_bits [$];

    bit          idle_on     = 1'b0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_hold   = 0;
    t_result     want;

    zone_bitmap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lowest clear bit among the first n_words words of the map, or -1 when
    // every one of those bits is set.
    function automatic int lowest_free_bit(int n_words);
        for (int w = 0; w < n_words; w++) begin
            if (used_map[w] != '1) begin
                for (int b = 0; b < WORD_BITS; b++) begin
                    if (!used_map[w][b]) return w * WORD_BITS + b;
                end
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow map and returns the result the block
    // must produce for it.
    function automatic t_result bitmap_outcome(t_cmd_code cmd, logic [ZONE_W-1:0] zone);
        t_result     res;
        int          blocks;
        int          bit_idx;
        int unsigned zone_sum;
        res.status = ST_OK;
        res.zone   = '0;
        if (cmd == CMD_ALLOC) begin
            // Block counts above the physical map size saturate.
            blocks  = (model_map_blocks > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : model_map_blocks;
            bit_idx = lowest_free_bit(blocks * WORDS_PER_BLOCK);
            if (bit_idx < 0) begin
                res.status = ST_FULL;
            end else begin
                used_map[bit_idx / WORD_BITS][bit_idx % WORD_BITS] = 1'b1;
                // The zone number wraps at 17 bits and is not checked
                // against zone_count.
                zone_sum = model_fdz + bit_idx;
                res.zone = zone_sum[ZONE_W-1:0];
                held_bits.push_back(bit_idx);
            end
        end else begin
            // A free answers zone 0 whatever happens; only the status varies.
            bit_idx = int'(zone) - int'(model_fdz);
            if (bit_idx < 0 || zone >= model_zone_count || bit_idx >= int'(TOTAL_BITS)) begin
                res.status = ST_RANGE;
            end else if (!used_map[bit_idx / WORD_BITS][bit_idx % WORD_BITS]) begin
                res.status = ST_CLEAR;
            end else begin
                used_map[bit_idx / WORD_BITS][bit_idx % WORD_BITS] = 1'b0;
            end
        end
        return res;
    endfunction

    // Presents one request and holds it until the transfer. Valid is only
    // lowered ahead of a gap, so back-to-back requests keep it high; every
    // caller that lets time pass afterwards lowers it first.
    task automatic send_req(input t_cmd_code cmd, input logic [ZONE_W-1:0] zone);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(TDATA_W-ZONE_W){1'b0}}, zone};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(bitmap_outcome(cmd, zone));
    endtask

    // Stops the request stream and waits for every owed result. Each request
    // yields exactly one result, so the block is idle once the queue is empty.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (addr)
            CFG_FIRST_DATA_ZONE: begin
                model_fdz = data[FDZ_W-1:0];
            end
            CFG_ZONE_COUNT: begin
                model_zone_count = data[ZONE_W-1:0];
            end
            CFG_MAP_BLOCKS: begin
                model_map_blocks = data[MBLK_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Programs all registers while the block is idle. The spare index gets a
    // random word first, and the bits above the map block count carry random
    // filler; both must be ignored.
    task automatic set_config(input logic [CFG_DW-1:0] fdz_word,
                              input logic [ZONE_W-1:0] count,
                              input logic [MBLK_W-1:0] blocks);
        logic [CFG_DW-1:0] junk;
        drain_results();
        junk = CFG_DW'($urandom());
        write_reg(CFG_SPARE, junk);
        write_reg(CFG_FIRST_DATA_ZONE, fdz_word);
        write_reg(CFG_ZONE_COUNT, count);
        write_reg(CFG_MAP_BLOCKS, {junk[CFG_DW-1:MBLK_W], blocks});
        i_cfg_valid <= 1'b0;
    endtask

    // Hand-picked requests that walk through the corner cases.
    task automatic test_directed();
        idle_on = 1'b1;
        // With no map blocks every allocation is refused; the zone field of
        // an allocation is ignored even when all ones.
        set_config('0, ZONE_W'(ZONE_MAX), 4'd0);
        send_req(CMD_ALLOC, ZONE_W'(ZONE_MAX));
        send_req(CMD_FREE, '0);                      // in range but never allocated
        send_req(CMD_FREE, ZONE_W'(ZONE_MAX));       // at zone_count, out of range
        // Largest base zone: allocations start at the top of the base zone range.
        set_config(CFG_DW'(FDZ_MAX), ZONE_W'(ZONE_MAX), 4'd1);
        repeat (3) send_req(CMD_ALLOC, '0);
        send_req(CMD_FREE, ZONE_W'(FDZ_MAX + 1));
        send_req(CMD_FREE, ZONE_W'(FDZ_MAX + 1));    // second free of the same zone
        send_req(CMD_FREE, ZONE_W'(FDZ_MAX - 1));    // just below the base zone
        send_req(CMD_ALLOC, '0);                     // reuses the freed hole
        send_req(CMD_FREE, ZONE_W'(ZONE_MAX - 1));   // last bit of the map, never set
        send_req(CMD_FREE, ZONE_W'(ZONE_MAX));
        // A block count above the map size saturates.
        set_config('0, ZONE_W'(ZONE_MAX), 4'd15);
        send_req(CMD_FREE, ZONE_W'(TOTAL_BITS));     // one past the end of the map
        send_req(CMD_ALLOC, '0);
        send_req(CMD_FREE, '0);
        // Zero zone count puts every free out of range.
        set_config(17'd100, '0, 4'd8);
        send_req(CMD_FREE, 17'd101);
        send_req(CMD_ALLOC, '0);
        // Bit 16 of the data word lies above the base zone register.
        set_config(17'h1_0005, ZONE_W'(ZONE_MAX), 4'd2);
        send_req(CMD_FREE, 17'd5);
        send_req(CMD_FREE, 17'd6);
    endtask

    // Random traffic over several register settings. Most frees target zones
    // that were really handed out; the rest probe the range edges or are noise.
    task automatic test_random_traffic();
        logic [CFG_DW-1:0] fdz_word;
        logic [ZONE_W-1:0] count;
        logic [MBLK_W-1:0] blocks;
        logic [ZONE_W-1:0] zone;
        int unsigned       pick;
        int unsigned       slot;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    fdz_word = CFG_DW'(FDZ_MAX);
                    count    = ZONE_W'(ZONE_MAX);
                    blocks   = 4'd15;
                end
                1: begin
                    fdz_word = '0;
                    count    = 17'd2000;
                    blocks   = 4'd1;
                end
                default: begin
                    fdz_word = ($urandom_range(0, 2) == 0) ? '0 : CFG_DW'($urandom());
                    case ($urandom_range(0, 3))
                        0: count = ZONE_W'(ZONE_MAX);
                        1: count = ZONE_W'(fdz_word[FDZ_W-1:0] + $urandom_range(0, 20000));
                        2: count = ZONE_W'($urandom());
                        default: count = '0;
                    endcase
                    case ($urandom_range(0, 9))
                        0: blocks = 4'd0;
                        1: blocks = MBLK_W'($urandom_range(9, 15));
                        default: blocks = MBLK_W'($urandom_range(1, 8));
                    endcase
                end
            endcase
            // One phase runs without any idling on either side.
            idle_on = (phase != 2);
            set_config(fdz_word, count, blocks);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                zone = ZONE_W'($urandom());
                if (pick < 45 || (pick < 80 && held_bits.size() == 0)) begin
                    send_req(CMD_ALLOC, zone);
                end else if (pick < 80) begin
                    slot = $urandom_range(0, held_bits.size() - 1);
                    zone = ZONE_W'(model_fdz + held_bits[slot]);
                    held_bits.delete(slot);
                    send_req(CMD_FREE, zone);
                end else if (pick < 92) begin
                    case ($urandom_range(0, 3))
                        0: zone = ZONE_W'(model_fdz - 1);
                        1: zone = ZONE_W'(model_fdz);
                        2: zone = ZONE_W'(model_zone_count - 1);
                        default: zone = model_zone_count;
                    endcase
                    send_req(CMD_FREE, zone);
                end else begin
                    send_req(CMD_FREE, zone);
                end
            end
        end
    endtask

    // Packs allocations into the low end of the first map block, then checks reuse
    // of freed holes, the search across a saturated block count and an allocation
    // with no map blocks. This is the final stretch of the run and has no idling.
    task automatic test_fill_block();
        idle_on = 1'b0;
        set_config(CFG_DW'($urandom_range(0, FDZ_MAX)), ZONE_W'(ZONE_MAX), 4'd1);
        repeat (11) send_req(CMD_ALLOC, ZONE_W'($urandom()));
        repeat (3) send_req(CMD_FREE, ZONE_W'(model_fdz + $urandom_range(0, WORD_BITS - 1)));
        repeat (4) send_req(CMD_ALLOC, ZONE_W'($urandom()));
        set_config(CFG_DW'(model_fdz), ZONE_W'(ZONE_MAX), 4'd9);
        repeat (2) send_req(CMD_ALLOC, ZONE_W'($urandom()));
        set_config(CFG_DW'(model_fdz), ZONE_W'(ZONE_MAX), 4'd0);
        send_req(CMD_ALLOC, ZONE_W'($urandom()));
    endtask

    // Result sink: ready drops for random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_hold == 1) begin
            sink_hold  <= 0;
            i_m_tready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_hold  <= $urandom_range(1, 15);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected, actual status %0d zone_out %0d",
                         $time, o_m_tuser, o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_m_tuser);
                end
                if (o_m_tdata !== {{(TDATA_W-ZONE_W){1'b0}}, want.zone}) begin
                    error_count++;
                    $display("%0t: zone_out mismatch, expected %0d, actual %0d",
                             $time, want.zone, o_m_tdata);
                end
            end
        end
    end

    // Watchdog: too many cycles without a transfer on any channel is a hang.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** zone_bitmap_allocator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (used_map[w]) used_map[w] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_fill_block();
        drain_results();
        // Give a stray late result time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** zone_bitmap_allocator: PASSED **");
        end else begin
            $display("** zone_bitmap_allocator: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/zba_pkg.sv
rtl/core/zba_dpath.sv
rtl/core/zba_ctrl.sv
rtl/core/zone_bitmap_allocator.sv
verif/zone_bitmap_allocator_tb.sv
